@@ hdl/qlb_pkg.sv @@
// qlb_pkg: shared types, constants and helpers for the quad lut bilinear correction unit
// used by qlb_weight_div, qlb_lane and quad_lut_bilinear_correction_unit
package qlb_pkg;

  // table and coordinate geometry
  localparam int LUT_ENTRIES = 256;
  localparam int LUT_AW      = $clog2(LUT_ENTRIES);
  localparam int COORD_BITS  = 12;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_LANES   = 3;

  // weights are q0.16, one extra bit holds exactly 1.0
  localparam int WEIGHT_FRAC = 16;
  localparam int WEIGHT_W    = WEIGHT_FRAC + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC;

  // divider pipeline: quotient bits resolved per stage
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = WEIGHT_FRAC / DIV_STEPS_PER_STAGE;

  // lane datapath
  localparam int LANE_LAT = 4;
  localparam int HPROD_W  = 8 + WEIGHT_W;
  localparam int VPROD_W  = 16 + WEIGHT_W;
  localparam int HSHIFT   = WEIGHT_FRAC - 8;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_PIXEL = 1'b1
  } qlb_mode_t;

  typedef enum logic {
    CFG_QUAD_WIDTH  = 1'b0,
    CFG_QUAD_HEIGHT = 1'b1
  } qlb_cfg_idx_t;

  typedef struct packed {
    qlb_mode_t             mode;
    logic [1:0]            corner;
    logic [7:0]            lut_index;
    logic [15:0]           red;
    logic [15:0]           green;
    logic [15:0]           blue;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
  } qlb_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } qlb_out_t;

  // per-lane table access for one issued transaction
  typedef struct packed {
    logic              wr_en;
    logic [1:0]        corner;
    logic [LUT_AW-1:0] wr_addr;
    logic [7:0]        wr_byte;
    logic [LUT_AW-1:0] rd_addr;
  } qlb_lane_req_t;

  // lookup address from a channel's upper byte, saturated to the last entry
  function automatic logic [LUT_AW-1:0] lut_rd_addr(input logic [7:0] hi);
    if (32'(hi) >= 32'(LUT_ENTRIES)) begin
      return LUT_AW'(LUT_ENTRIES - 1);
    end
    return LUT_AW'(hi);
  endfunction

  // load addresses past the table are dropped
  function automatic logic lut_wr_ok(input logic [7:0] addr);
    return 32'(addr) < 32'(LUT_ENTRIES);
  endfunction

endpackage

@@ hdl/qlb_weight_div.sv @@
// qlb_weight_div: pipelined restoring divider producing a saturated q0.16 weight
// computes min(pos * 2^16 / divisor, 1.0); depends on qlb_pkg
module qlb_weight_div (
  input  logic                              clk,
  input  logic [qlb_pkg::COORD_BITS-1:0]    pos,
  input  logic [qlb_pkg::COORD_BITS-1:0]    divisor,
  output logic [qlb_pkg::WEIGHT_W-1:0]      weight
);
  import qlb_pkg::*;

  logic [COORD_BITS-1:0]  rem_r [DIV_STAGES];
  logic [WEIGHT_FRAC-1:0] quo_r [DIV_STAGES];
  logic                   sat_r [DIV_STAGES];

  // one restoring step: returns quotient bit and new remainder
  function automatic logic [COORD_BITS:0] div_step(input logic [COORD_BITS-1:0] rem,
                                                   input logic [COORD_BITS-1:0] dv);
    logic [COORD_BITS:0] dbl;
    logic [COORD_BITS:0] dif;
    dbl = {rem, 1'b0};
    dif = dbl - {1'b0, dv};
    if (dbl >= {1'b0, dv}) begin
      return {1'b1, dif[COORD_BITS-1:0]};
    end
    return {1'b0, dbl[COORD_BITS-1:0]};
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [COORD_BITS-1:0]  rem_in;
    logic [WEIGHT_FRAC-1:0] quo_in;
    logic                   sat_in;
    logic [COORD_BITS-1:0]  rem_nxt;
    logic [WEIGHT_FRAC-1:0] quo_nxt;

    // stage input: raw position or previous stage
    if (s == 0) begin : g_first
      always_comb begin
        sat_in = (pos >= divisor);
        rem_in = sat_in ? '0 : pos;
        quo_in = '0;
      end
    end else begin : g_next
      always_comb begin
        sat_in = sat_r[s-1];
        rem_in = rem_r[s-1];
        quo_in = quo_r[s-1];
      end
    end

    // resolve a few quotient bits
    always_comb begin
      logic [COORD_BITS:0] st;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        st      = div_step(rem_nxt, divisor);
        rem_nxt = st[COORD_BITS-1:0];
        quo_nxt = {quo_nxt[WEIGHT_FRAC-2:0], st[COORD_BITS]};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
      sat_r[s] <= sat_in;
    end
  end

  // position at or past the divisor saturates to 1.0
  assign weight = sat_r[DIV_STAGES-1] ? WEIGHT_ONE : {1'b0, quo_r[DIV_STAGES-1]};

endmodule

@@ hdl/qlb_lane.sv @@
// qlb_lane: one color channel: four corner tables and the bilinear blend
// depends on qlb_pkg for widths and the lane request struct
module qlb_lane (
  input  logic                          clk,
  input  qlb_pkg::qlb_lane_req_t        req,
  input  logic [qlb_pkg::WEIGHT_W-1:0]  wx,
  input  logic [qlb_pkg::WEIGHT_W-1:0]  wy,
  output logic [15:0]                   result
);
  import qlb_pkg::*;

  logic [7:0]          ent_r [NUM_CORNERS];
  logic [WEIGHT_W-1:0] wx1_r;
  logic [WEIGHT_W-1:0] wy1_r;
  logic [HPROD_W-1:0]  hprod_r [NUM_CORNERS];
  logic [WEIGHT_W-1:0] wy2_r;
  logic [15:0]         top_r;
  logic [15:0]         bot_r;
  logic [WEIGHT_W-1:0] wy3_r;
  logic [VPROD_W-1:0]  vprod_r [2];
  logic [HPROD_W:0]    top_sum;
  logic [HPROD_W:0]    bot_sum;
  logic [VPROD_W:0]    vsum;

  // corner tables, one write and one registered read per cycle each
  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    logic [7:0] lut_mem_r [LUT_ENTRIES];

    always_ff @(posedge clk) begin
      if (req.wr_en && (req.corner == 2'(k))) begin
        lut_mem_r[req.wr_addr] <= req.wr_byte;
      end
      ent_r[k] <= lut_mem_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    wx1_r <= wx;
    wy1_r <= wy;
  end

  // horizontal products; corners 0,2 take 1-wx and corners 1,3 take wx
  always_ff @(posedge clk) begin
    hprod_r[0] <= HPROD_W'(ent_r[0]) * HPROD_W'(WEIGHT_ONE - wx1_r);
    hprod_r[1] <= HPROD_W'(ent_r[1]) * HPROD_W'(wx1_r);
    hprod_r[2] <= HPROD_W'(ent_r[2]) * HPROD_W'(WEIGHT_ONE - wx1_r);
    hprod_r[3] <= HPROD_W'(ent_r[3]) * HPROD_W'(wx1_r);
    wy2_r      <= wy1_r;
  end

  // top and bottom blends, entry scaled by 256 folded into the shift
  assign top_sum = {1'b0, hprod_r[0]} + {1'b0, hprod_r[1]};
  assign bot_sum = {1'b0, hprod_r[2]} + {1'b0, hprod_r[3]};

  always_ff @(posedge clk) begin
    top_r <= top_sum[HSHIFT+15:HSHIFT];
    bot_r <= bot_sum[HSHIFT+15:HSHIFT];
    wy3_r <= wy2_r;
  end

  // vertical products
  always_ff @(posedge clk) begin
    vprod_r[0] <= VPROD_W'(top_r) * VPROD_W'(WEIGHT_ONE - wy3_r);
    vprod_r[1] <= VPROD_W'(bot_r) * VPROD_W'(wy3_r);
  end

  // final blend, truncated
  assign vsum   = {1'b0, vprod_r[0]} + {1'b0, vprod_r[1]};
  assign result = vsum[WEIGHT_FRAC+15:WEIGHT_FRAC];

endmodule

@@ hdl/quad_lut_bilinear_correction_unit.sv @@
// quad_lut_bilinear_correction_unit: top level, weight dividers, three channel lanes
// and the merge register; depends on qlb_pkg, qlb_weight_div and qlb_lane
//
// usage:
//   input channel: a transaction on in_data is taken at each rising edge with start
//   high and busy low. busy stays low, so one transaction may enter every cycle.
//   mode load writes one entry (low byte of each channel) into the corner table
//   selected by corner at lut_index and gives no result; mode pixel gives one result.
//   result channel: out_valid is high for one cycle with out_data; the receiver cannot
//   stall, so results leave in input order with fixed timing.
//   pipeline: a pixel's result is registered on out_data after 8 stages of the weight
//   divider, two quotient bits each, then 4 lane stages: table read, horizontal
//   products, top/bottom blend, vertical products, then merge.
//   throughput: one transaction per clock, loads and pixels mixed freely; table writes
//   happen in the same pipeline slot as table reads, so order is kept.
//   configuration: cfg_we writes quad_width (index 0) or quad_height (index 1) at once;
//   write only while no transaction is in flight. A zero divisor acts as one.
//   reset: synchronous active-low rst_n clears the pipeline valids and sets both
//   divisors to 1; table contents are undefined until loaded.
module quad_lut_bilinear_correction_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  qlb_pkg::qlb_in_t               in_data,
  output logic                           out_valid,
  output qlb_pkg::qlb_out_t              out_data,
  input  logic                           cfg_we,
  input  qlb_pkg::qlb_cfg_idx_t          cfg_index,
  input  logic [qlb_pkg::COORD_BITS-1:0] cfg_data
);
  import qlb_pkg::*;

  logic [COORD_BITS-1:0] quad_width_r;
  logic [COORD_BITS-1:0] quad_height_r;
  logic [COORD_BITS-1:0] div_x;
  logic [COORD_BITS-1:0] div_y;
  logic                  in_fire;
  logic                  ctl_v_r [DIV_STAGES];
  qlb_in_t               ctl_r   [DIV_STAGES];
  logic                  lane_v_r [LANE_LAT];
  logic [WEIGHT_W-1:0]   wx;
  logic [WEIGHT_W-1:0]   wy;
  logic                  pix_issue;
  logic                  load_issue;
  logic [15:0]           chan [NUM_LANES];
  qlb_lane_req_t         lane_req [NUM_LANES];
  logic [15:0]           lane_res [NUM_LANES];
  logic                  out_valid_r;
  qlb_out_t              out_data_r;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_width_r  <= COORD_BITS'(1);
      quad_height_r <= COORD_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUAD_WIDTH:  quad_width_r  <= cfg_data;
        CFG_QUAD_HEIGHT: quad_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign div_x = (quad_width_r == '0)  ? COORD_BITS'(1) : quad_width_r;
  assign div_y = (quad_height_r == '0) ? COORD_BITS'(1) : quad_height_r;

  // weight dividers
  qlb_weight_div u_div_x (
    .clk     (clk),
    .pos     (in_data.pos_x),
    .divisor (div_x),
    .weight  (wx)
  );

  qlb_weight_div u_div_y (
    .clk     (clk),
    .pos     (in_data.pos_y),
    .divisor (div_y),
    .weight  (wy)
  );

  // transaction delay line alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) ctl_v_r[i] <= 1'b0;
    end else begin
      ctl_v_r[0] <= in_fire;
      for (int i = 1; i < DIV_STAGES; i++) ctl_v_r[i] <= ctl_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= in_data;
    for (int i = 1; i < DIV_STAGES; i++) ctl_r[i] <= ctl_r[i-1];
  end

  // issue to the lanes once weights are ready
  assign pix_issue  = ctl_v_r[DIV_STAGES-1] && (ctl_r[DIV_STAGES-1].mode == MODE_PIXEL);
  assign load_issue = ctl_v_r[DIV_STAGES-1] && (ctl_r[DIV_STAGES-1].mode == MODE_LOAD);

  assign chan[0] = ctl_r[DIV_STAGES-1].red;
  assign chan[1] = ctl_r[DIV_STAGES-1].green;
  assign chan[2] = ctl_r[DIV_STAGES-1].blue;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    always_comb begin
      lane_req[c].wr_en   = load_issue && lut_wr_ok(ctl_r[DIV_STAGES-1].lut_index);
      lane_req[c].corner  = ctl_r[DIV_STAGES-1].corner;
      lane_req[c].wr_addr = LUT_AW'(ctl_r[DIV_STAGES-1].lut_index);
      lane_req[c].wr_byte = chan[c][7:0];
      lane_req[c].rd_addr = lut_rd_addr(chan[c][15:8]);
    end

    qlb_lane u_lane (
      .clk    (clk),
      .req    (lane_req[c]),
      .wx     (wx),
      .wy     (wy),
      .result (lane_res[c])
    );
  end

  // lane valid tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) lane_v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lane_v_r[0] <= pix_issue;
      for (int i = 1; i < LANE_LAT; i++) lane_v_r[i] <= lane_v_r[i-1];
      out_valid_r <= lane_v_r[LANE_LAT-1];
    end
  end

  // merge lanes into the result register
  always_ff @(posedge clk) begin
    out_data_r.out_red   <= lane_res[0];
    out_data_r.out_green <= lane_res[1];
    out_data_r.out_blue  <= lane_res[2];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only ever follows a pixel issue
  a_out_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(pix_issue, LANE_LAT + 1))
    else $error("result strobe without a pixel issue");

  // load transactions never start lane work
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_issue |=> !lane_v_r[0])
    else $error("load transaction produced lane work");

  // weights reaching the lanes never exceed one
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    pix_issue |-> (wx <= WEIGHT_ONE && wy <= WEIGHT_ONE))
    else $error("weight above one");

  // every accepted pixel leaves after the fixed latency
  a_pixel_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.mode == MODE_PIXEL) |-> ##(DIV_STAGES + LANE_LAT + 1) out_valid_r)
    else $error("pixel result missing at expected cycle");

endmodule

@@ tb/testbench.sv @@
// testbench for quad_lut_bilinear_correction_unit: loads the four corner tables, streams
// pixels in random bursts and checks every corrected pixel against a local blend model
// depends on qlb_pkg and the unit's top level only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qlb_pkg::*;

  localparam int LATENCY_DRAIN = 24;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int RANDOM_ITEMS  = 1930;
  localparam int NUM_PHASES    = 6;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  qlb_in_t  in_data;
  logic     out_valid;
  qlb_out_t out_data;
  logic     cfg_we;
  qlb_cfg_idx_t cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  quad_lut_bilinear_correction_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // transactions waiting to be driven and corrected pixels waiting to come out
  qlb_in_t  pending_items[$];
  qlb_out_t expected_pixels[$];

  // local copy of the divisors and the corner tables
  logic [COORD_BITS-1:0] quad_width_q;
  logic [COORD_BITS-1:0] quad_height_q;
  logic [7:0] corner_lut [NUM_CORNERS][LUT_ENTRIES][NUM_LANES];

  // stimulus side bookkeeping: which entries are loaded in all four corners
  bit entry_loaded [NUM_CORNERS][LUT_ENTRIES];
  bit entry_ready  [LUT_ENTRIES];
  int ready_index[$];

  int cycle_count;
  int fail_count;
  int pixel_count;
  int load_count;
  int burst_left;
  int gap_left;

  // q0.16 weight from a position and a divisor, saturated at one
  function automatic logic [WEIGHT_W-1:0] axis_weight(input logic [COORD_BITS-1:0] pos,
                                                      input logic [COORD_BITS-1:0] div);
    longint unsigned d;
    longint unsigned w;
    d = (div == '0) ? 64'd1 : 64'(div);
    w = (64'(pos) << WEIGHT_FRAC) / d;
    if (w > 64'(WEIGHT_ONE)) w = 64'(WEIGHT_ONE);
    return w[WEIGHT_W-1:0];
  endfunction

  // a*(1-w) + b*w, truncated
  function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                      input logic [WEIGHT_W-1:0] w);
    longint unsigned s;
    s = 64'(a) * (64'(WEIGHT_ONE) - 64'(w)) + 64'(b) * 64'(w);
    return s[WEIGHT_FRAC +: 16];
  endfunction

  // corrected pixel from the local tables and divisors
  function automatic qlb_out_t correct_pixel(input qlb_in_t px);
    logic [15:0] chan [NUM_LANES];
    logic [15:0] corner_val [NUM_CORNERS];
    logic [15:0] res [NUM_LANES];
    logic [WEIGHT_W-1:0] wx;
    logic [WEIGHT_W-1:0] wy;
    int idx;
    qlb_out_t r;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    wx = axis_weight(px.pos_x, quad_width_q);
    wy = axis_weight(px.pos_y, quad_height_q);
    for (int c = 0; c < NUM_LANES; c++) begin
      idx = int'(chan[c][15:8]);
      if (idx >= LUT_ENTRIES) idx = LUT_ENTRIES - 1;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        corner_val[k] = {corner_lut[k][idx][c], 8'h00};
      end
      res[c] = mix(mix(corner_val[0], corner_val[1], wx),
                   mix(corner_val[2], corner_val[3], wx), wy);
    end
    r.out_red   = res[0];
    r.out_green = res[1];
    r.out_blue  = res[2];
    return r;
  endfunction

  // table write for a load transaction
  function automatic void store_entry(input qlb_in_t ld);
    if (int'(ld.lut_index) < LUT_ENTRIES) begin
      corner_lut[ld.corner][ld.lut_index][0] = ld.red[7:0];
      corner_lut[ld.corner][ld.lut_index][1] = ld.green[7:0];
      corner_lut[ld.corner][ld.lut_index][2] = ld.blue[7:0];
    end
  endfunction

  // queue one load and keep track of fully loaded entries
  task automatic push_load(input logic [1:0] corner, input logic [7:0] idx,
                           input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
    qlb_in_t t;
    t.mode      = MODE_LOAD;
    t.corner    = corner;
    t.lut_index = idx;
    t.red       = r;
    t.green     = g;
    t.blue      = b;
    t.pos_x     = COORD_BITS'($urandom);
    t.pos_y     = COORD_BITS'($urandom);
    pending_items.push_back(t);
    if (int'(idx) < LUT_ENTRIES) begin
      entry_loaded[corner][idx] = 1'b1;
      if (!entry_ready[idx] && entry_loaded[0][idx] && entry_loaded[1][idx] &&
          entry_loaded[2][idx] && entry_loaded[3][idx]) begin
        entry_ready[idx] = 1'b1;
        ready_index.push_back(int'(idx));
      end
    end
  endtask

  // queue one pixel, unused fields random
  task automatic push_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    qlb_in_t t;
    t.mode      = MODE_PIXEL;
    t.corner    = 2'($urandom);
    t.lut_index = 8'($urandom);
    t.red       = r;
    t.green     = g;
    t.blue      = b;
    t.pos_x     = x;
    t.pos_y     = y;
    pending_items.push_back(t);
  endtask

  // channel value whose upper byte hits an entry loaded in every corner
  function automatic logic [15:0] loaded_channel();
    return {8'(ready_index[$urandom_range(0, ready_index.size() - 1)]), 8'($urandom)};
  endfunction

  // position along one axis, biased toward zero, the edge and beyond
  function automatic logic [COORD_BITS-1:0] axis_pos(input logic [COORD_BITS-1:0] div);
    unique case ($urandom_range(0, 5))
      0: return '0;
      1: return div;
      2: return '1;
      3, 4: return COORD_BITS'($urandom_range(0, int'(div)));
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // register write, one cycle of write enable
  task automatic write_cfg(input qlb_cfg_idx_t idx, input logic [COORD_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_QUAD_WIDTH) quad_width_q = value;
    else quad_height_q = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until the driver is drained and all results are in, then let loads settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || start || expected_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY_DRAIN) @(negedge clk);
  endtask

  // random mix of load sequences, stray loads and pixels
  task automatic random_phase(input int count);
    int n;
    int sel;
    int s;
    int len;
    logic [7:0] idx;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 16) begin
        // well-formed sequence: one entry loaded in all four corners
        idx = 8'($urandom);
        s = $urandom_range(0, 3);
        for (int k = 0; k < NUM_CORNERS; k++) begin
          push_load(2'(s + k), idx, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        n += NUM_CORNERS;
      end else if (sel < 24) begin
        // broken sequence or lone load
        idx = 8'($urandom);
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          push_load(2'($urandom), idx, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        n += len;
      end else begin
        push_pixel(loaded_channel(), loaded_channel(), loaded_channel(),
                   axis_pos(quad_width_q), axis_pos(quad_height_q));
        n++;
      end
    end
  endtask

  // driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        if (in_data.mode == MODE_PIXEL) begin
          expected_pixels.push_back(correct_pixel(in_data));
          pixel_count++;
        end else begin
          store_entry(in_data);
          load_count++;
        end
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          start   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // one output field against its expectation
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin : monitor
    qlb_out_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result with no pixel pending: %h", out_data);
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_blue", want.out_blue, out_data.out_blue);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus and configuration phases
  initial begin
    int waited;
    logic [COORD_BITS-1:0] widths  [NUM_PHASES];
    logic [COORD_BITS-1:0] heights [NUM_PHASES];
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_QUAD_WIDTH;
    cfg_data      = '0;
    quad_width_q  = 12'd1;
    quad_height_q = 12'd1;
    cycle_count   = 0;
    fail_count    = 0;
    pixel_count   = 0;
    load_count    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small quadrant, table extremes, corner and edge positions
    write_cfg(CFG_QUAD_WIDTH, 12'd16);
    write_cfg(CFG_QUAD_HEIGHT, 12'd8);
    push_load(2'd0, 8'd0, 16'hFF10, 16'h00FF, 16'hA501);
    push_load(2'd1, 8'd0, 16'hFF90, 16'h0000, 16'h5A02);
    push_load(2'd2, 8'd0, 16'hFF40, 16'hFF00, 16'h0080);
    push_load(2'd3, 8'd0, 16'hFFF0, 16'hFFFF, 16'hFF7F);
    push_load(2'd0, 8'd255, 16'h00FF, 16'h5A00, 16'h003C);
    push_load(2'd1, 8'd255, 16'hFF00, 16'hA5FF, 16'h003D);
    push_load(2'd2, 8'd255, 16'h0055, 16'h00AA, 16'hC33E);
    push_load(2'd3, 8'd255, 16'hABAA, 16'h0055, 16'h3C3F);
    push_pixel(16'h00FF, 16'hFF00, 16'hFFFF, 12'd0, 12'd0);
    push_pixel(16'h00FF, 16'hFF00, 16'hFFFF, 12'd16, 12'd0);
    push_pixel(16'h00FF, 16'hFF00, 16'hFFFF, 12'd0, 12'd8);
    push_pixel(16'h00FF, 16'hFF00, 16'hFFFF, 12'd16, 12'd8);
    push_pixel(16'hFF00, 16'h0000, 16'h00FF, 12'd8, 12'd4);
    push_pixel(16'hFFFF, 16'h00FF, 16'hFF00, 12'd5, 12'd3);
    // positions past the quadrant saturate to the far corners, then one just inside
    push_pixel(16'h0000, 16'hFFFF, 16'h0000, 12'd4095, 12'd4095);
    push_pixel(16'hFF80, 16'h0080, 16'hFF7F, 12'd4095, 12'd0);
    push_pixel(16'h00FF, 16'hFFFF, 16'hFF00, 12'd15, 12'd7);
    // overwrite an entry, then read it back through a pixel
    push_load(2'd0, 8'd255, 16'hFF00, 16'hFF00, 16'hFF00);
    push_pixel(16'hFF00, 16'hFF00, 16'hFF00, 12'd3, 12'd1);
    wait_idle();

    // random phases across divisor settings, zero and full scale among them
    widths[0]  = 12'd4095;                      heights[0] = 12'd4095;
    widths[1]  = 12'd0;                         heights[1] = 12'd0;
    widths[2]  = 12'd1;                         heights[2] = 12'd1;
    widths[3]  = 12'($urandom_range(1, 4095));  heights[3] = 12'($urandom_range(1, 4095));
    widths[4]  = 12'd3;                         heights[4] = 12'd4095;
    widths[5]  = 12'($urandom_range(1, 64));    heights[5] = 12'($urandom_range(1, 64));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_QUAD_WIDTH, widths[p]);
      write_cfg(CFG_QUAD_HEIGHT, heights[p]);
      random_phase(RANDOM_ITEMS / NUM_PHASES);
      wait_idle();
    end

    // final drain with a bound, leftovers count as failures
    waited = 0;
    while (expected_pixels.size() != 0 && waited < 200) begin
      @(negedge clk);
      waited++;
    end
    fail_count += expected_pixels.size();

    $display("ran %0d transactions: %0d pixels, %0d table loads, %0d divisor settings",
             pixel_count + load_count, pixel_count, load_count, NUM_PHASES + 1);
    $display("%0d table entries loaded in all four corners, %0d failures",
             ready_index.size(), fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
